FILE: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

    // Command codes carried in the opcode field
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_opcode;

    // Bus phase of the running command; idle means no command in progress
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_SECOND = 3'd2,
        PH_THIRD  = 3'd3,
        PH_FOURTH = 3'd4
    } t_phase;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    // One input beat: a single clock tick of the bus sequencer
    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] opcode;
        logic [7:0] write_data;
        logic       nack_after_read;
        logic       sda_sample;
    } t_in_item;

    // One result beat, produced for every input beat
    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_missing;
    } t_out_item;

    // Sequencer state carried from tick to tick
    typedef struct packed {
        t_opcode     command_kind;
        t_phase      phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [15:0] phase_timer;
        logic        scl_level;
        logic        sda_level;
        logic        ack_flag;
        logic        nack_choice;
    } t_state;

endpackage

FILE: sv/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: beat registers, state and config.
// Each input beat is one tick of an open-drain I2C master sequencer and yields exactly one
// result beat carrying the SCL/SDA release levels, busy, a done pulse, the read byte and the
// missing-ack flag. A beat passes an input register, one step of sequencer logic and a result
// register, and the result register holds its result until the output side takes it at a clock
// edge; one beat is taken every cycle while the result side keeps up. While a result
// waits on the output, the input register takes at most one more beat and then holds ready
// low. Commands (start, stop, write byte with ack check, read byte with ACK or NACK) are
// taken only when idle, and every bus phase lasts half_period_ticks beats, with zero acting
// as one. i_cfg_we writes half_period_ticks (reset 250) and must only be used while no beat
// is in flight; a write during a command affects only the phases loaded after it.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic        r_in_valid;
    t_in_item    r_in_item;
    t_state      r_state;
    logic        r_out_valid;
    t_out_item   r_out_item;
    logic [15:0] r_half_period;
    t_state      n_state;
    t_out_item   n_out_item;
    logic        step_go;

    // Move a beat from the input register to the result register
    assign step_go    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step_go;

    i2cm_step u_step (
        .i_state       (r_state),
        .i_item        (r_in_item),
        .i_half_period (r_half_period),
        .o_state       (n_state),
        .o_result      (n_out_item)
    );

    // Hold the period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    // Capture input beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Advance sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.command_kind <= OP_START;
            r_state.phase        <= PH_IDLE;
            r_state.bit_count    <= 4'd0;
            r_state.shift_byte   <= 8'd0;
            r_state.phase_timer  <= 16'd0;
            r_state.scl_level    <= 1'b1;
            r_state.sda_level    <= 1'b1;
            r_state.ack_flag     <= 1'b0;
            r_state.nack_choice  <= 1'b0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // Hold result beats until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.done_res) |-> !r_out_item.busy_res)
        else $error("done beat still reports busy");

    a_ack_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.ack_missing) |-> r_out_item.done_res)
        else $error("ack_missing outside a done beat");

    a_idle_timer_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == PH_IDLE) |-> (r_state.phase_timer == 16'd0))
        else $error("phase timer running while idle");

    a_busy_timer_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_IDLE) |-> (r_state.phase_timer != 16'd0))
        else $error("phase timer empty during a command");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.bit_count <= BITS_PER_BYTE)
        else $error("bit count beyond one byte");

    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

FILE: sv/i2cm_step.sv
// One-tick update of the I2C bit sequencer: next state and result beat.
module i2cm_step
    import i2cm_pkg::*;
(
    input  t_state      i_state,
    input  t_in_item    i_item,
    input  logic [15:0] i_half_period,
    output t_state      o_state,
    output t_out_item   o_result
);

    t_phase      n_phase;
    t_state      n_state;
    logic        busy;
    logic        expired;
    logic        done;
    logic [15:0] load_ticks;
    logic [3:0]  cnt_inc;
    logic [7:0]  shift_nx;
    logic        is_write;

    // Decode common terms
    assign busy       = (i_state.phase != PH_IDLE);
    assign expired    = (i_state.phase_timer <= 16'd1);
    assign load_ticks = (i_half_period == 16'd0) ? 16'd1 : i_half_period;
    assign cnt_inc    = i_state.bit_count + 4'd1;
    assign is_write   = (i_state.command_kind == OP_WRITE);
    assign shift_nx   = is_write ? {i_state.shift_byte[6:0], 1'b0}
                                 : {i_state.shift_byte[6:0], i_item.sda_sample};

    // Next phase
    always_comb begin
        n_phase = i_state.phase;
        if (!busy) begin
            if (i_item.cmd_valid) begin
                n_phase = PH_FIRST;
            end
        end else if (expired) begin
            case (i_state.command_kind)
                OP_START: begin
                    n_phase = (i_state.phase == PH_FIRST) ? PH_SECOND : PH_IDLE;
                end
                OP_STOP: begin
                    case (i_state.phase)
                        PH_FIRST:  n_phase = PH_SECOND;
                        PH_SECOND: n_phase = PH_THIRD;
                        default:   n_phase = PH_IDLE;
                    endcase
                end
                default: begin
                    case (i_state.phase)
                        PH_FIRST:  n_phase = PH_SECOND;
                        PH_SECOND: n_phase = (cnt_inc >= BITS_PER_BYTE) ? PH_THIRD
                                                                        : PH_FIRST;
                        PH_THIRD:  n_phase = PH_FOURTH;
                        default:   n_phase = PH_IDLE;
                    endcase
                end
            endcase
        end
    end

    assign done = busy && expired && (n_phase == PH_IDLE);

    // Line levels, data path and phase timer
    always_comb begin
        n_state       = i_state;
        n_state.phase = n_phase;
        if (!busy) begin
            if (i_item.cmd_valid) begin
                n_state.command_kind = t_opcode'(i_item.opcode);
                n_state.bit_count    = 4'd0;
                n_state.phase_timer  = load_ticks;
                case (t_opcode'(i_item.opcode))
                    OP_START: begin
                        n_state.scl_level = 1'b1;
                        n_state.sda_level = 1'b1;
                    end
                    OP_STOP: begin
                        n_state.scl_level = 1'b0;
                        n_state.sda_level = 1'b0;
                    end
                    OP_WRITE: begin
                        n_state.shift_byte = i_item.write_data;
                        n_state.ack_flag   = 1'b0;
                        n_state.scl_level  = 1'b0;
                        n_state.sda_level  = i_item.write_data[7];
                    end
                    default: begin
                        n_state.shift_byte  = 8'd0;
                        n_state.nack_choice = i_item.nack_after_read;
                        n_state.scl_level   = 1'b0;
                        n_state.sda_level   = 1'b1;
                    end
                endcase
            end
        end else if (!expired) begin
            n_state.phase_timer = i_state.phase_timer - 16'd1;
        end else begin
            n_state.phase_timer = done ? 16'd0 : load_ticks;
            case (i_state.command_kind)
                OP_START: begin
                    if (i_state.phase == PH_FIRST) begin
                        n_state.scl_level = 1'b1;
                        n_state.sda_level = 1'b0;
                    end else begin
                        n_state.scl_level = 1'b0;
                    end
                end
                OP_STOP: begin
                    case (i_state.phase)
                        PH_FIRST: begin
                            n_state.scl_level = 1'b1;
                            n_state.sda_level = 1'b0;
                        end
                        PH_SECOND: begin
                            n_state.scl_level = 1'b1;
                            n_state.sda_level = 1'b1;
                        end
                        default: ;
                    endcase
                end
                default: begin
                    case (i_state.phase)
                        PH_FIRST: begin
                            n_state.scl_level = 1'b1;
                        end
                        PH_SECOND: begin
                            // shift one bit, then go to the next bit or the ack bit
                            n_state.shift_byte = shift_nx;
                            n_state.bit_count  = cnt_inc;
                            n_state.scl_level  = 1'b0;
                            if (cnt_inc >= BITS_PER_BYTE) begin
                                n_state.sda_level = is_write ? 1'b1 : i_state.nack_choice;
                            end else begin
                                n_state.sda_level = is_write ? shift_nx[7] : 1'b1;
                            end
                        end
                        PH_THIRD: begin
                            n_state.scl_level = 1'b1;
                        end
                        default: begin
                            // end of ack bit: sample on write, pull SCL low
                            if (is_write) begin
                                n_state.ack_flag = i_item.sda_sample;
                            end
                            n_state.scl_level = 1'b0;
                        end
                    endcase
                end
            endcase
        end
    end

    // Drive result beat
    assign o_state              = n_state;
    assign o_result.scl_release = n_state.scl_level;
    assign o_result.sda_release = n_state.sda_level;
    assign o_result.busy_res    = (n_phase != PH_IDLE);
    assign o_result.done_res    = done;
    assign o_result.read_data   = (done && i_state.command_kind == OP_READ)
                                  ? n_state.shift_byte : 8'd0;
    assign o_result.ack_missing = done && is_write && n_state.ack_flag;

endmodule

FILE: dv/i2c_master_bit_engine_monitor.sv
// Beat monitor for the I2C master bit engine: tracks the sequencer and compares every result.
module i2c_master_bit_engine_monitor
    import i2cm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_item,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_item,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    // Tracked bus sequencer state
    logic [15:0] period;
    t_opcode     cur_cmd;
    t_phase      cur_ph;
    logic [3:0]  bits_done;
    logic [7:0]  shreg;
    logic [15:0] ticks_left;
    logic        scl_q;
    logic        sda_q;
    logic        ack_q;
    logic        nack_q;

    // Line levels and flags expected for beats still in flight
    t_out_item   expected_levels[$];

    // Enter a bus phase; a zero period behaves as one tick
    task automatic load_phase(input t_phase ph, input logic scl, input logic sda);
        cur_ph     = ph;
        ticks_left = (period == 16'd0) ? 16'd1 : period;
        scl_q      = scl;
        sda_q      = sda;
    endtask

    // Move on once the current phase has run its full length
    task automatic close_phase(input logic sda_in, output logic fin);
        fin = 1'b0;
        case (cur_cmd)
            OP_START: begin
                if (cur_ph == PH_FIRST) begin
                    load_phase(PH_SECOND, 1'b1, 1'b0);
                end else begin
                    scl_q = 1'b0;
                    fin   = 1'b1;
                end
            end
            OP_STOP: begin
                if (cur_ph == PH_FIRST) begin
                    load_phase(PH_SECOND, 1'b1, 1'b0);
                end else if (cur_ph == PH_SECOND) begin
                    load_phase(PH_THIRD, 1'b1, 1'b1);
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
                case (cur_ph)
                    PH_FIRST: begin
                        load_phase(PH_SECOND, 1'b1, sda_q);
                    end
                    PH_SECOND: begin
                        // shift out on write, shift in the sampled line on read
                        shreg     = (cur_cmd == OP_WRITE) ? {shreg[6:0], 1'b0}
                                                          : {shreg[6:0], sda_in};
                        bits_done = bits_done + 4'd1;
                        if (bits_done >= BITS_PER_BYTE) begin
                            load_phase(PH_THIRD, 1'b0, (cur_cmd == OP_WRITE) ? 1'b1 : nack_q);
                        end else begin
                            load_phase(PH_FIRST, 1'b0, (cur_cmd == OP_WRITE) ? shreg[7] : 1'b1);
                        end
                    end
                    PH_THIRD: begin
                        load_phase(PH_FOURTH, 1'b1, sda_q);
                    end
                    default: begin
                        // ack bit over: latch the slave's answer, pull SCL low
                        if (cur_cmd == OP_WRITE) begin
                            ack_q = sda_in;
                        end
                        scl_q = 1'b0;
                        fin   = 1'b1;
                    end
                endcase
            end
        endcase
        if (fin) begin
            cur_ph     = PH_IDLE;
            ticks_left = '0;
        end
    endtask

    // Advance the sequencer by one tick and form the result of that tick
    task automatic step_sequencer(input t_in_item beat, output t_out_item res);
        logic fin;
        fin = 1'b0;
        if (cur_ph == PH_IDLE) begin
            if (beat.cmd_valid) begin
                cur_cmd   = t_opcode'(beat.opcode);
                bits_done = '0;
                case (cur_cmd)
                    OP_START: begin
                        load_phase(PH_FIRST, 1'b1, 1'b1);
                    end
                    OP_STOP: begin
                        load_phase(PH_FIRST, 1'b0, 1'b0);
                    end
                    OP_WRITE: begin
                        shreg = beat.write_data;
                        ack_q = 1'b0;
                        load_phase(PH_FIRST, 1'b0, beat.write_data[7]);
                    end
                    default: begin
                        shreg  = '0;
                        nack_q = beat.nack_after_read;
                        load_phase(PH_FIRST, 1'b0, 1'b1);
                    end
                endcase
            end
        end else if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 16'd1;
        end else begin
            close_phase(beat.sda_sample, fin);
        end
        res.scl_release = scl_q;
        res.sda_release = sda_q;
        res.busy_res    = (cur_ph != PH_IDLE);
        res.done_res    = fin;
        res.read_data   = (fin && cur_cmd == OP_READ) ? shreg : 8'd0;
        res.ack_missing = (fin && cur_cmd == OP_WRITE) ? ack_q : 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    // Check result beats in order, then fold in config writes and new input beats
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            period       = HALF_PERIOD_RESET;
            cur_cmd      = OP_START;
            cur_ph       = PH_IDLE;
            bits_done    = '0;
            shreg        = '0;
            ticks_left   = '0;
            scl_q        = 1'b1;
            sda_q        = 1'b1;
            ack_q        = 1'b0;
            nack_q       = 1'b0;
            o_fail_count = 0;
            expected_levels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %0h",
                             $time, i_out_item);
                    o_fail_count++;
                end else begin
                    want = expected_levels.pop_front();
                    compare_field("scl_release", want.scl_release, i_out_item.scl_release);
                    compare_field("sda_release", want.sda_release, i_out_item.sda_release);
                    compare_field("busy_res", want.busy_res, i_out_item.busy_res);
                    compare_field("done_res", want.done_res, i_out_item.done_res);
                    compare_field("read_data", want.read_data, i_out_item.read_data);
                    compare_field("ack_missing", want.ack_missing, i_out_item.ack_missing);
                end
            end
            if (i_cfg_we) begin
                period = i_cfg_wdata;
            end
            if (i_in_valid && i_in_ready) begin
                step_sequencer(i_in_item, want);
                expected_levels.push_back(want);
            end
        end
        o_pending = expected_levels.size();
    end

endmodule

FILE: dv/i2c_master_bit_engine_test.sv
// Stimulus and verdict for the I2C master bit engine: bus commands, tick streams, stalls.
module i2c_master_bit_engine_test;
    import i2cm_pkg::*;

    typedef enum int {
        SDA_LOW,
        SDA_ONE,
        SDA_RAND
    } t_sda_drive;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          beats_sent    = 0;
    int          beats_got     = 0;
    logic        last_busy     = 1'b0;
    int          send_idle_pct = 33;
    int          recv_idle_pct = 71;
    logic [15:0] period_now    = HALF_PERIOD_RESET;
    t_sda_drive  sda_drive     = SDA_RAND;

    i2c_master_bit_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    i2c_master_bit_engine_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result side at random, count beats and keep the latest busy flag
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (out_valid && out_ready) begin
            beats_got <= beats_got + 1;
            last_busy <= out_item.busy_res;
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #16000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic line_level();
        case (sda_drive)
            SDA_LOW:  return 1'b0;
            SDA_ONE:  return 1'b1;
            default:  return 1'($urandom_range(1));
        endcase
    endfunction

    function automatic t_in_item random_tick();
        t_in_item t;
        t.cmd_valid       = 1'($urandom_range(1));
        t.opcode          = 2'($urandom_range(3));
        t.write_data      = 8'($urandom_range(255));
        t.nack_after_read = 1'($urandom_range(1));
        t.sda_sample      = line_level();
        return t;
    endfunction

    function automatic t_in_item quiet_tick();
        t_in_item t;
        t           = random_tick();
        t.cmd_valid = 1'b0;
        return t;
    endfunction

    // Offer one beat after a random gap and hold it until taken
    task automatic send_beat(input t_in_item beat);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
    endtask

    // Hold off the sender until every result beat is back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (beats_got != beats_sent);
    endtask

    // Feed empty ticks until the bus command in progress is over
    task automatic run_to_idle();
        settle();
        while (last_busy) begin
            repeat ((period_now > 16'd16) ? 64 : 4) send_beat(quiet_tick());
            settle();
        end
    endtask

    task automatic write_period(input logic [15:0] value);
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        period_now = value;
        @(posedge clk);
        cfg_we     <= 1'b0;
    endtask

    task automatic issue(input t_opcode op, input logic [7:0] data, input logic nack);
        t_in_item t;
        t                 = random_tick();
        t.cmd_valid       = 1'b1;
        t.opcode          = op;
        t.write_data      = data;
        t.nack_after_read = nack;
        send_beat(t);
    endtask

    task automatic do_command(input t_opcode op, input logic [7:0] data, input logic nack);
        issue(op, data, nack);
        run_to_idle();
    endtask

    // Start, a few random data bytes, stop, at a random bus speed
    task automatic random_transfer();
        int n;
        case ($urandom_range(9))
            0:       write_period(16'd0);
            1:       write_period(16'($urandom_range(4, 9)));
            default: write_period(16'($urandom_range(1, 3)));
        endcase
        case ($urandom_range(7))
            0:       sda_drive = SDA_LOW;
            1:       sda_drive = SDA_ONE;
            default: sda_drive = SDA_RAND;
        endcase
        do_command(OP_START, 8'($urandom_range(255)), 1'($urandom_range(1)));
        n = $urandom_range(1, 3);
        repeat (n) begin
            do_command($urandom_range(1) ? OP_WRITE : OP_READ, 8'($urandom_range(255)),
                       1'($urandom_range(1)));
        end
        do_command(OP_STOP, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Fully random ticks, commands offered whether busy or not
    task automatic random_noise();
        sda_drive = SDA_RAND;
        repeat ($urandom_range(5, 30)) send_beat(random_tick());
        run_to_idle();
    endtask

    initial begin : stimulus
        int       mark;
        t_in_item poke;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset period: the first phase of a start runs the default 250 ticks,
        // then a faster period finishes the command
        issue(OP_START, 8'h00, 1'b0);
        repeat (240) send_beat(quiet_tick());
        settle();
        write_period(16'd1);
        run_to_idle();

        // Zero period acts as one tick; byte extremes, ack and nack, all commands
        write_period(16'd0);
        do_command(OP_START, 8'h00, 1'b0);
        sda_drive = SDA_LOW;
        do_command(OP_WRITE, 8'hFF, 1'b0);
        sda_drive = SDA_ONE;
        do_command(OP_WRITE, 8'h00, 1'b1);
        do_command(OP_READ, 8'h00, 1'b0);
        sda_drive = SDA_LOW;
        do_command(OP_READ, 8'hFF, 1'b1);
        sda_drive = SDA_RAND;
        do_command(OP_READ, 8'h5A, 1'b0);
        do_command(OP_WRITE, 8'hA5, 1'b0);
        do_command(OP_STOP, 8'h00, 1'b0);

        // Commands offered all through a busy write, its done tick included
        write_period(16'd1);
        do_command(OP_START, 8'h00, 1'b0);
        issue(OP_WRITE, 8'h3C, 1'b0);
        repeat (40) begin
            poke           = random_tick();
            poke.cmd_valid = 1'b1;
            send_beat(poke);
        end
        run_to_idle();

        // Period changes in the middle of a read
        write_period(16'd5);
        issue(OP_READ, 8'h00, 1'b1);
        repeat (7) send_beat(quiet_tick());
        settle();
        write_period(16'd2);
        repeat (12) send_beat(quiet_tick());
        settle();
        write_period(16'd3);
        run_to_idle();
        do_command(OP_STOP, 8'h00, 1'b0);

        // Random transfers under each idling mix
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct = 71;
                end
                1: begin
                    send_idle_pct = 71;
                    recv_idle_pct = 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            mark = beats_sent;
            while (beats_sent - mark < 60) begin
                if ($urandom_range(9) < 2) begin
                    random_noise();
                end else begin
                    random_transfer();
                end
            end
        end

        // Slowest bus speed: a start condition holds its first phase
        write_period(16'hFFFF);
        sda_drive = SDA_RAND;
        issue(OP_START, 8'h00, 1'b0);
        repeat (16) send_beat(quiet_tick());
        settle();

        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
